// ===== rtl/rtc_bcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC BCD decode package
// Shared constants and helper functions for turning raw BCD clock registers
// into binary calendar fields.
// ----------------------------------------------------------------------------
package rtc_bcd_pkg;

    // Field masks applied to the raw clock registers.
    localparam logic [7:0] SEC_MASK  = 8'h7F;
    localparam logic [7:0] MIN_MASK  = 8'h7F;
    localparam logic [7:0] HR24_MASK = 8'h3F;
    localparam logic [7:0] HR12_MASK = 8'h1F;
    localparam logic [7:0] DATE_MASK = 8'h3F;
    localparam logic [7:0] MON_MASK  = 8'h1F;

    // Hour register mode and meridiem bits.
    localparam int unsigned HR_MODE12_BIT = 7;
    localparam int unsigned HR_PM_BIT     = 5;

    // Year range handled by the calendar check.
    localparam logic [11:0] YEAR_BASE   = 12'd2000;
    localparam logic [7:0]  YEAR_OFFSET_MAX = 8'd99;

    // Largest legal values of the time fields.
    localparam logic [7:0] SEC_MAX    = 8'd59;
    localparam logic [7:0] MIN_MAX    = 8'd59;
    localparam logic [7:0] HOUR24_MAX = 8'd23;
    localparam logic [7:0] HOUR12_MAX = 8'd12;

    // Two-digit BCD to binary, high nibble times ten plus low nibble.
    // Nibbles above nine are taken at face value (result up to 165).
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] raw);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'b0000, raw[7:4]};
        lo = {4'b0000, raw[3:0]};
        return 8'((hi << 3) + (hi << 1) + lo);
    endfunction

    // Days in a month; zero for a month code outside 1..12.
    function automatic logic [4:0] month_days(input logic [7:0] mon, input logic leap);
        logic [4:0] days;
        unique case (mon)
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: days = 5'd31;
            8'd4, 8'd6, 8'd9, 8'd11:                   days = 5'd30;
            8'd2:                                      days = leap ? 5'd29 : 5'd28;
            default:                                   days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== rtl/rtc_bcd_registers_to_date_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC BCD registers to date and time
// Decodes the seven raw registers of a BCD real-time clock into a checked
// binary calendar date and 24-hour time.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_ready) carries one word: the seconds,
// minutes, hours, date, month, weekday and year registers as read from the
// clock. The output channel (out_valid / out_ready) returns one word per
// input word: valid_res and the decoded year, month, day, weekday, hour,
// minute and second. When any field fails its range, month-length or leap
// February check, valid_res is 0 and every other field is 0.
// A word is captured in an input register, decoded by short combinational
// logic and captured in a result register, which presents it on the output
// channel. Throughput is one word per cycle while the receiver does not
// stall, set by the two register stages that each advance whenever the
// stage after them is free or being emptied.
// When the receiver stalls, the result register holds its word and the
// input register may still fill, after which in_ready drops. Reset clears
// both stage valid flags; the payload registers are not reset.
// ----------------------------------------------------------------------------
module rtc_bcd_registers_to_date_time (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seconds_reg,
    input  logic [7:0]  minutes_reg,
    input  logic [7:0]  hours_reg,
    input  logic [7:0]  date_reg,
    input  logic [7:0]  month_reg,
    input  logic [7:0]  weekday_reg,
    input  logic [7:0]  year_reg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [2:0]  weekday,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    // Stage control.
    logic in_vld_reg;
    logic out_vld_reg;
    logic out_free;
    logic in_adv;

    // Input register payload.
    logic [7:0] sec_raw_reg;
    logic [7:0] min_raw_reg;
    logic [7:0] hr_raw_reg;
    logic [7:0] date_raw_reg;
    logic [7:0] mon_raw_reg;
    logic [7:0] wd_raw_reg;
    logic [7:0] yr_raw_reg;

    // Decoded values.
    logic [7:0]  sec_bin;
    logic [7:0]  min_bin;
    logic [7:0]  day_bin;
    logic [7:0]  mon_bin;
    logic [7:0]  yr_bin;
    logic [7:0]  h12_bin;
    logic [7:0]  h24_bin;
    logic [2:0]  wd_bin;
    logic        pm;
    logic        mode12;
    logic        leap;
    logic [4:0]  dim;
    logic [4:0]  hour_calc;
    logic        hour_ok;
    logic        all_ok;

    // Result register payload.
    logic        valid_res_reg;
    logic        valid_res_next;
    logic [11:0] year_res_reg;
    logic [11:0] year_next;
    logic [3:0]  month_res_reg;
    logic [3:0]  month_next;
    logic [4:0]  day_res_reg;
    logic [4:0]  day_next;
    logic [2:0]  weekday_res_reg;
    logic [2:0]  weekday_next;
    logic [4:0]  hour_res_reg;
    logic [4:0]  hour_next;
    logic [5:0]  minute_res_reg;
    logic [5:0]  minute_next;
    logic [5:0]  second_res_reg;
    logic [5:0]  second_next;

    // Handshake: each stage advances when the stage after it is free.
    assign out_free = !out_vld_reg || out_ready;
    assign in_adv   = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || out_free;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Input register capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sec_raw_reg  <= seconds_reg;
            min_raw_reg  <= minutes_reg;
            hr_raw_reg   <= hours_reg;
            date_raw_reg <= date_reg;
            mon_raw_reg  <= month_reg;
            wd_raw_reg   <= weekday_reg;
            yr_raw_reg   <= year_reg;
        end
    end

    // BCD decode of every field but the weekday, which takes the low three bits.
    always_comb
    begin
        sec_bin = rtc_bcd_pkg::bcd_to_bin(sec_raw_reg & rtc_bcd_pkg::SEC_MASK);
        min_bin = rtc_bcd_pkg::bcd_to_bin(min_raw_reg & rtc_bcd_pkg::MIN_MASK);
        day_bin = rtc_bcd_pkg::bcd_to_bin(date_raw_reg & rtc_bcd_pkg::DATE_MASK);
        mon_bin = rtc_bcd_pkg::bcd_to_bin(mon_raw_reg & rtc_bcd_pkg::MON_MASK);
        yr_bin  = rtc_bcd_pkg::bcd_to_bin(yr_raw_reg);
        h12_bin = rtc_bcd_pkg::bcd_to_bin(hr_raw_reg & rtc_bcd_pkg::HR12_MASK);
        h24_bin = rtc_bcd_pkg::bcd_to_bin(hr_raw_reg & rtc_bcd_pkg::HR24_MASK);
        wd_bin  = wd_raw_reg[2:0];
        mode12  = hr_raw_reg[rtc_bcd_pkg::HR_MODE12_BIT];
        pm      = hr_raw_reg[rtc_bcd_pkg::HR_PM_BIT];
    end

    // Hour conversion to 24-hour form with its range check.
    always_comb
    begin
        hour_calc = 5'd0;
        hour_ok   = 1'b1;
        if (mode12)
        begin
            if (h12_bin == 8'd0 || h12_bin > rtc_bcd_pkg::HOUR12_MAX)
            begin
                hour_ok = 1'b0;
            end
            else if (h12_bin == rtc_bcd_pkg::HOUR12_MAX)
            begin
                hour_calc = pm ? 5'd12 : 5'd0;
            end
            else
            begin
                hour_calc = pm ? 5'(h12_bin + 8'd12) : h12_bin[4:0];
            end
        end
        else
        begin
            hour_ok   = (h24_bin <= rtc_bcd_pkg::HOUR24_MAX);
            hour_calc = h24_bin[4:0];
        end
    end

    // Calendar check. Within 2000..2099 a year is leap when its offset is a
    // multiple of four (2000 itself is a multiple of 400).
    always_comb
    begin
        leap   = (yr_bin[1:0] == 2'b00);
        dim    = rtc_bcd_pkg::month_days(mon_bin, leap);
        all_ok = hour_ok
              && (sec_bin <= rtc_bcd_pkg::SEC_MAX)
              && (min_bin <= rtc_bcd_pkg::MIN_MAX)
              && (wd_bin != 3'd0)
              && (yr_bin <= rtc_bcd_pkg::YEAR_OFFSET_MAX)
              && (dim != 5'd0)
              && (day_bin != 8'd0)
              && (day_bin <= {3'b000, dim});
    end

    // Result word, forced to zero when any check fails.
    always_comb
    begin
        valid_res_next = all_ok;
        year_next      = 12'd0;
        month_next     = 4'd0;
        day_next       = 5'd0;
        weekday_next   = 3'd0;
        hour_next      = 5'd0;
        minute_next    = 6'd0;
        second_next    = 6'd0;
        if (all_ok)
        begin
            year_next    = rtc_bcd_pkg::YEAR_BASE + {4'b0000, yr_bin};
            month_next   = mon_bin[3:0];
            day_next     = day_bin[4:0];
            weekday_next = wd_bin;
            hour_next    = hour_calc;
            minute_next  = min_bin[5:0];
            second_next  = sec_bin[5:0];
        end
    end

    // Result register capture.
    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            valid_res_reg   <= valid_res_next;
            year_res_reg    <= year_next;
            month_res_reg   <= month_next;
            day_res_reg     <= day_next;
            weekday_res_reg <= weekday_next;
            hour_res_reg    <= hour_next;
            minute_res_reg  <= minute_next;
            second_res_reg  <= second_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign valid_res = valid_res_reg;
    assign year      = year_res_reg;
    assign month     = month_res_reg;
    assign day       = day_res_reg;
    assign weekday   = weekday_res_reg;
    assign hour      = hour_res_reg;
    assign minute    = minute_res_reg;
    assign second    = second_res_reg;

    // A rejected word carries only zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (year == 12'd0 && month == 4'd0 && day == 5'd0
            && weekday == 3'd0 && hour == 5'd0 && minute == 6'd0 && second == 6'd0))
    else $error("rejected result word has nonzero fields");

    // An accepted word lies within the calendar and clock ranges.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |-> (year >= 12'd2000 && year <= 12'd2099
            && month != 4'd0 && month <= 4'd12 && day != 5'd0 && weekday != 3'd0
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("accepted result word out of range");

    // A word waiting in the input register is not lost while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_free) |=> in_vld_reg)
    else $error("input word dropped during output stall");

    // Every word leaving the input register lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_adv |=> out_vld_reg)
    else $error("decoded word not captured in result register");

endmodule
